// ----- rtl/pta_pkg.sv -----
// Shared constants, types and helper functions of the pixel to ASCII text encoder.
package pta_pkg;

   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 400;
   localparam int RAMP_STEPS   = 58;
   localparam int TABLE_LEN    = 58;

   localparam int COUNT_W = 12;
   localparam int SUM_W   = 10;
   localparam int IDX_W   = $clog2(RAMP_STEPS + 1);
   localparam int TAB_W   = $clog2(TABLE_LEN);
   localparam int LEVEL_W = SUM_W + IDX_W;

   // floor(x / 765) == ((x + 1) * RECIP_MUL) >> RECIP_SHIFT over the level range
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_MUL   = (2 ** RECIP_SHIFT) / 765;
   localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
   localparam int PMUL_W      = LEVEL_W + 1 + RECIP_W;

   localparam logic [23:0] COLOR_RESET = 24'hFFFF00;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRKT = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_EM    = 8'h6D;
   localparam logic [7:0] CH_NL    = 8'h0A;

   localparam logic [7:0] RAMP [TABLE_LEN] = '{
      8'h20, 8'h20, 8'h5F, 8'h5F, 8'h2D, 8'h2D, 8'h3C, 8'h3C,
      8'h5C, 8'h2F, 8'h5C, 8'h2F, 8'h7E, 8'h7E, 8'h23, 8'h23,
      8'hE2, 8'h96, 8'h91, 8'hE2, 8'h96, 8'h91,
      8'hE2, 8'h96, 8'h92, 8'hE2, 8'h96, 8'h92,
      8'hE2, 8'h96, 8'h93, 8'hE2, 8'h96, 8'h93,
      8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88,
      8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88,
      8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88
   };

   typedef struct packed {
      logic        esc;
      logic        eol;
      logic        rst;
      logic [11:0] red_dig;
      logic [11:0] green_dig;
      logic [11:0] blue_dig;
      logic [7:0]  glyph;
   } cmd_type;

   function automatic logic [7:0] ramp_byte(input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      if (int'(idx) >= TABLE_LEN) begin
         b = RAMP[TABLE_LEN-1];
      end else begin
         b = RAMP[TAB_W'(idx)];
      end
      return b;
   endfunction

   // three BCD digits of an 8-bit value
   function automatic logic [11:0] dec3(input logic [7:0] v);
      logic [1:0]  hun;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      if (v >= 8'd200) begin
         hun = 2'd2;
         rem = 7'(v - 8'd200);
      end else if (v >= 8'd100) begin
         hun = 2'd1;
         rem = 7'(v - 8'd100);
      end else begin
         hun = 2'd0;
         rem = v[6:0];
      end
      prod = 15'(rem) * 15'd205;
      tens = prod[14:11];
      ones = rem - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
      return {2'b00, hun, tens, ones[3:0]};
   endfunction

endpackage

// ----- rtl/pta_front.sv -----
// Front end: accepts pixels, tracks color and raster position, builds byte commands.
module pta_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              color_mode,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   output logic              push,
   output pta_pkg::cmd_type  push_cmd,
   input  logic              full
);
   import pta_pkg::*;

   logic                prev_color_ff, prev_color_in;
   logic [23:0]         color_ff, color_in;
   logic [COUNT_W-1:0]  col_ff, col_in;
   logic [COUNT_W-1:0]  row_ff, row_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_esc_ff, s1_esc_in;
   logic                s1_eol_ff, s1_eol_in;
   logic                s1_rst_ff, s1_rst_in;
   logic [7:0]          s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [LEVEL_W-1:0]  s1_level_ff, s1_level_in;

   logic                s2_valid_ff, s2_valid_in;
   cmd_type             s2_cmd_ff, s2_cmd_in;
   logic [PMUL_W-1:0]   s2_prod_ff, s2_prod_in;

   logic                accept;
   logic                s2_load;
   logic [23:0]         rgb;
   logic                esc;
   logic                eol;
   logic                eof;
   logic [SUM_W-1:0]    sum;
   logic [IDX_W-1:0]    quot;
   logic [IDX_W-1:0]    idx;

   assign push      = s2_valid_ff && !full;
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || push);
   assign req_stall = s1_valid_ff && !s2_load;
   assign accept    = req_valid && !req_stall;

   assign rgb = {req_red, req_green, req_blue};
   assign esc = color_mode && (rgb != color_ff);
   assign eol = col_ff >= COUNT_W'(FRAME_WIDTH - 1);
   assign eof = row_ff >= COUNT_W'(FRAME_HEIGHT - 1);
   assign sum = SUM_W'(req_red) + SUM_W'(req_green) + SUM_W'(req_blue);

   // raster and color state
   always_comb begin
      color_in      = color_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      prev_color_in = prev_color_ff;
      if (accept) begin
         prev_color_in = 1'b1;
         if (esc) begin
            color_in = rgb;
         end
         if (eol) begin
            col_in = '0;
            if (eof) begin
               row_in   = '0;
               color_in = COLOR_RESET;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      s1_esc_in   = esc;
      s1_eol_in   = eol;
      s1_rst_in   = eol && eof && color_mode;
      s1_level_in = LEVEL_W'(sum) * LEVEL_W'(RAMP_STEPS);
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (push) begin
         s2_valid_in = 1'b0;
      end
      s2_cmd_in.esc       = s1_esc_ff;
      s2_cmd_in.eol       = s1_eol_ff;
      s2_cmd_in.rst       = s1_rst_ff;
      s2_cmd_in.red_dig   = dec3(s1_red_ff);
      s2_cmd_in.green_dig = dec3(s1_green_ff);
      s2_cmd_in.blue_dig  = dec3(s1_blue_ff);
      s2_cmd_in.glyph     = '0;
      s2_prod_in = PMUL_W'({1'b0, s1_level_ff} + 1'b1) * PMUL_W'(RECIP_MUL);
   end

   assign quot = s2_prod_ff[RECIP_SHIFT +: IDX_W];
   assign idx  = (quot >= IDX_W'(RAMP_STEPS - 1)) ? IDX_W'(RAMP_STEPS - 1) : quot;

   always_comb begin
      push_cmd       = s2_cmd_ff;
      push_cmd.glyph = ramp_byte(idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_color_ff <= 1'b0;
         color_ff      <= COLOR_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         prev_color_ff <= prev_color_in;
         color_ff      <= color_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_esc_ff   <= s1_esc_in;
         s1_eol_ff   <= s1_eol_in;
         s1_rst_ff   <= s1_rst_in;
         s1_red_ff   <= req_red;
         s1_green_ff <= req_green;
         s1_blue_ff  <= req_blue;
         s1_level_ff <= s1_level_in;
      end
      if (s2_load) begin
         s2_cmd_ff  <= s2_cmd_in;
         s2_prod_ff <= s2_prod_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty first stage");
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> s1_valid_ff)
      else $error("first stage dropped a transaction");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> prev_color_ff)
      else $error("accept not recorded");
`endif

endmodule

// ----- rtl/pta_queue.sv -----
// Short command queue between the front end and the byte sequencer.
module pta_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pta_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output pta_pkg::cmd_type  head,
   output logic              empty
);
   import pta_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(count_ff))
      else $error("queue count moved without push or pop");
`endif

endmodule

// ----- rtl/pta_back.sv -----
// Back end: walks one command through its byte sequence into the output register.
module pta_back (
   input  logic              clock,
   input  logic              reset,
   input  pta_pkg::cmd_type  head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_text_byte,
   output logic              rsp_last_of_run
);
   import pta_pkg::*;

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_ESC   = 3'd1;
   localparam logic [2:0] PH_CH0   = 3'd2;
   localparam logic [2:0] PH_CH1   = 3'd3;
   localparam logic [2:0] PH_NL    = 3'd4;
   localparam logic [2:0] PH_RST   = 3'd5;

   localparam logic [4:0] ESC_LAST = 5'd18;
   localparam logic [4:0] RST_LAST = 5'd3;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   logic        load;
   logic [2:0]  cur_phase;
   logic [2:0]  next_phase;
   logic [4:0]  next_pos;
   logic [7:0]  out_byte;
   logic        out_last;
   logic [7:0]  esc_byte;

   assign load      = !empty && (!rsp_valid_ff || !rsp_stall);
   assign cur_phase = (phase_ff == PH_START) ? (head.esc ? PH_ESC : PH_CH0) : phase_ff;

   always_comb begin
      case (pos_ff)
         5'd0:    esc_byte = CH_ESC;
         5'd1:    esc_byte = CH_LBRKT;
         5'd2:    esc_byte = CH_THREE;
         5'd3:    esc_byte = CH_EIGHT;
         5'd5:    esc_byte = CH_TWO;
         5'd7:    esc_byte = CH_ZERO + {4'b0, head.red_dig[11:8]};
         5'd8:    esc_byte = CH_ZERO + {4'b0, head.red_dig[7:4]};
         5'd9:    esc_byte = CH_ZERO + {4'b0, head.red_dig[3:0]};
         5'd11:   esc_byte = CH_ZERO + {4'b0, head.green_dig[11:8]};
         5'd12:   esc_byte = CH_ZERO + {4'b0, head.green_dig[7:4]};
         5'd13:   esc_byte = CH_ZERO + {4'b0, head.green_dig[3:0]};
         5'd15:   esc_byte = CH_ZERO + {4'b0, head.blue_dig[11:8]};
         5'd16:   esc_byte = CH_ZERO + {4'b0, head.blue_dig[7:4]};
         5'd17:   esc_byte = CH_ZERO + {4'b0, head.blue_dig[3:0]};
         5'd18:   esc_byte = CH_EM;
         default: esc_byte = CH_SEMI;
      endcase
   end

   always_comb begin
      next_phase = PH_START;
      next_pos   = '0;
      out_last   = 1'b0;
      unique case (cur_phase)
         PH_ESC: begin
            out_byte = esc_byte;
            if (pos_ff == ESC_LAST) begin
               next_phase = PH_CH0;
            end else begin
               next_phase = PH_ESC;
               next_pos   = pos_ff + 1'b1;
            end
         end
         PH_CH0: begin
            out_byte   = head.glyph;
            next_phase = PH_CH1;
         end
         PH_CH1: begin
            out_byte = head.glyph;
            if (head.eol) begin
               next_phase = PH_NL;
            end else begin
               out_last = 1'b1;
            end
         end
         PH_NL: begin
            out_byte = CH_NL;
            if (head.rst) begin
               next_phase = PH_RST;
            end else begin
               out_last = 1'b1;
            end
         end
         PH_RST: begin
            case (pos_ff)
               5'd0:    out_byte = CH_ESC;
               5'd1:    out_byte = CH_LBRKT;
               5'd2:    out_byte = CH_ZERO;
               default: out_byte = CH_EM;
            endcase
            if (pos_ff == RST_LAST) begin
               out_last = 1'b1;
            end else begin
               next_phase = PH_RST;
               next_pos   = pos_ff + 1'b1;
            end
         end
         default: begin
            out_byte = head.glyph;
         end
      endcase
   end

   assign pop = load && out_last;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         phase_in     = next_phase;
         pos_in       = next_pos;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_byte   = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (phase_ff == PH_START && pos_ff == '0))
      else $error("sequencer not rewound after last byte");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_START) |-> !empty)
      else $error("command left queue mid-sequence");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RST) |-> (pos_ff <= RST_LAST))
      else $error("reset sequence position out of range");
`endif

endmodule

// ----- rtl/pixel_to_ascii_text_encoder.sv -----
// Top level of the pixel to ASCII text encoder: register port and pipeline.
// One RGB pixel per req transaction in raster order, one text byte per rsp transaction.
// A pixel without a color escape produces 2 bytes, plus a newline at the end of a row;
// in color mode a color change adds 19 escape bytes and the end of a frame adds 4 reset
// bytes. The byte sequencer emits one byte per cycle while rsp_stall is low, so it sets the
// sustained pixel rate. The front end is two registered stages followed by a 4-entry command
// queue, so the first byte of a pixel passes both stages, the queue and the output register
// before it leaves.
// Register color_mode sits at byte address 0; write it only while the block is idle.
module pixel_to_ascii_text_encoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_red,
   input  logic [7:0]   req_green,
   input  logic [7:0]   req_blue,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_text_byte,
   output logic         rsp_last_of_run,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import pta_pkg::*;

   logic     mode_ff, mode_in;
   logic     csr_wr;
   logic     sel_mode;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;
   cmd_type  push_cmd;
   cmd_type  head;

   assign csr_pready = 1'b1;
   assign sel_mode   = (csr_paddr == 3'd0);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign mode_in    = (csr_wr && sel_mode) ? csr_pwdata[0] : mode_ff;
   assign csr_prdata = sel_mode ? {31'b0, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   pta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .color_mode (mode_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full)
   );

   pta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   pta_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- dv/tb_pixel_to_ascii_text_encoder.sv -----
// Self-checking testbench for the pixel to ASCII text encoder: random and directed pixels.
module tb_pixel_to_ascii_text_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 9;
   localparam int FRAME_W         = 640;
   localparam int FRAME_H         = 400;
   localparam int RAMP_LEN        = 58;
   localparam int SUM_FULL_SCALE  = 765;
   localparam int DRAIN_CYCLES    = 12;
   localparam int PHASE_PIXELS    = 33;
   localparam longint LIMIT_CYCLES = 5_000_000;

   localparam logic [2:0]  CSR_COLOR_MODE = 3'd0;
   localparam logic [2:0]  CSR_UNMAPPED   = 3'd4;
   localparam logic [23:0] COLOR_AT_RESET = 24'hFFFF00;

   localparam logic [7:0] ASC_ESC      = 8'h1B;
   localparam logic [7:0] ASC_LBRACKET = 8'h5B;
   localparam logic [7:0] ASC_SEMI     = 8'h3B;
   localparam logic [7:0] ASC_ZERO     = 8'h30;
   localparam logic [7:0] ASC_TWO      = 8'h32;
   localparam logic [7:0] ASC_THREE    = 8'h33;
   localparam logic [7:0] ASC_EIGHT    = 8'h38;
   localparam logic [7:0] ASC_M        = 8'h6D;
   localparam logic [7:0] ASC_NL       = 8'h0A;

   localparam logic [7:0] GLYPH_RAMP [RAMP_LEN] = '{
      8'h20, 8'h20, 8'h5F, 8'h5F, 8'h2D, 8'h2D, 8'h3C, 8'h3C,
      8'h5C, 8'h2F, 8'h5C, 8'h2F, 8'h7E, 8'h7E, 8'h23, 8'h23,
      8'hE2, 8'h96, 8'h91, 8'hE2, 8'h96, 8'h91,
      8'hE2, 8'h96, 8'h92, 8'hE2, 8'h96, 8'h92,
      8'hE2, 8'h96, 8'h93, 8'hE2, 8'h96, 8'h93,
      8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88,
      8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88,
      8'hE2, 8'h96, 8'h88, 8'hE2, 8'h96, 8'h88
   };

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } text_out_type;

   class text_stream_scoreboard;
      bit           color_on;
      logic [23:0]  shown_rgb;
      int unsigned  col;
      int unsigned  row;
      logic [7:0]   run_q[$];
      text_out_type expected_text_q[$];
      int unsigned  mismatch_count;

      function new();
         color_on       = 1'b0;
         shown_rgb      = COLOR_AT_RESET;
         col            = 0;
         row            = 0;
         mismatch_count = 0;
      endfunction

      function int unsigned pending_bytes();
         return expected_text_q.size();
      endfunction

      function void push_byte(input logic [7:0] b);
         run_q.push_back(b);
      endfunction

      function void push_decimal(input logic [7:0] v);
         push_byte(ASC_ZERO + v / 8'd100);
         push_byte(ASC_ZERO + (v / 8'd10) % 8'd10);
         push_byte(ASC_ZERO + v % 8'd10);
      endfunction

      function void note_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
         logic [23:0]  rgb;
         int unsigned  level;
         text_out_type item;
         rgb = {r, g, b};
         run_q.delete();
         if (color_on && rgb != shown_rgb) begin
            push_byte(ASC_ESC);
            push_byte(ASC_LBRACKET);
            push_byte(ASC_THREE);
            push_byte(ASC_EIGHT);
            push_byte(ASC_SEMI);
            push_byte(ASC_TWO);
            push_byte(ASC_SEMI);
            push_decimal(r);
            push_byte(ASC_SEMI);
            push_decimal(g);
            push_byte(ASC_SEMI);
            push_decimal(b);
            push_byte(ASC_M);
            shown_rgb = rgb;
         end
         level = (int'(r) + int'(g) + int'(b)) * RAMP_LEN / SUM_FULL_SCALE;
         if (level >= RAMP_LEN) begin
            level = RAMP_LEN - 1;
         end
         push_byte(GLYPH_RAMP[level]);
         push_byte(GLYPH_RAMP[level]);
         if (col + 1 >= FRAME_W) begin
            col = 0;
            push_byte(ASC_NL);
            if (row + 1 >= FRAME_H) begin
               row = 0;
               if (color_on) begin
                  push_byte(ASC_ESC);
                  push_byte(ASC_LBRACKET);
                  push_byte(ASC_ZERO);
                  push_byte(ASC_M);
               end
               shown_rgb = COLOR_AT_RESET;
            end else begin
               row = row + 1;
            end
         end else begin
            col = col + 1;
         end
         foreach (run_q[i]) begin
            item.text = run_q[i];
            item.last = (i == run_q.size() - 1);
            expected_text_q.push_back(item);
         end
      endfunction

      task report_mismatch(input string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_text_byte(input logic [7:0] text, input logic last);
         text_out_type want;
         if (expected_text_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", text, last));
         end else begin
            want = expected_text_q.pop_front();
            if (text !== want.text) begin
               report_mismatch($sformatf("text_byte %02h, expected %02h", text, want.text));
            end
            if (last !== want.last) begin
               report_mismatch($sformatf("last_of_run %0b, expected %0b", last, want.last));
            end
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = 8'h00;
   logic [7:0]  req_green = 8'h00;
   logic [7:0]  req_blue = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_text_byte;
   logic        rsp_last_of_run;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_stream_scoreboard sb;
   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   logic [23:0]  last_rgb = COLOR_AT_RESET;

   pixel_to_ascii_text_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_text_byte(rsp_text_byte, rsp_last_of_run);
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_pixel(r, g, b);
      last_rgb = {r, g, b};
   endtask

   task automatic send_random(input int unsigned n);
      logic [7:0]  r, g, b;
      int unsigned pick;
      repeat (n) begin
         pick = $urandom_range(9);
         {r, g, b} = 24'($urandom);
         if (pick == 4 || pick == 5) begin
            r = $urandom_range(1) ? 8'hFF : 8'h00;
            g = $urandom_range(1) ? 8'hFF : 8'h00;
            b = $urandom_range(1) ? 8'hFF : 8'h00;
         end else if (pick == 6 || pick == 7) begin
            {r, g, b} = last_rgb;
         end else if (pick == 8) begin
            {r, g, b} = COLOR_AT_RESET;
         end else if (pick == 9) begin
            r = 8'($urandom_range(15));
            g = 8'($urandom_range(15));
            b = 8'($urandom_range(15));
         end
         send_pixel(r, g, b);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_bytes() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_COLOR_MODE) begin
         sb.color_on = data[0];
      end
   endtask

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("tb_pixel_to_ascii_text_encoder: FAIL");
      $finish;
   end

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain text: extremes, clamp on white, gradient step edges
      csr_write(CSR_COLOR_MODE, 32'hFFFF_FFFE);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h0D, 8'h00, 8'h00);
      send_pixel(8'h0E, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFE);
      csr_write(CSR_UNMAPPED, 32'h0000_0001);
      send_pixel(8'h0A, 8'h14, 8'h1E);

      // color: reset color needs no escape, repeats need none, digit padding
      csr_write(CSR_COLOR_MODE, 32'h8000_0001);
      send_pixel(8'hFF, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h01, 8'h02, 8'h0A);
      send_pixel(8'h64, 8'hC8, 8'h09);
      send_pixel(8'hFF, 8'hFF, 8'h00);

      // stale stored color across a mode change
      csr_write(CSR_COLOR_MODE, 32'h0);
      send_pixel(8'h01, 8'h02, 8'h03);
      csr_write(CSR_COLOR_MODE, 32'h1);
      send_pixel(8'hFF, 8'hFF, 8'h00);
      send_pixel(8'h01, 8'h02, 8'h03);

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(CSR_COLOR_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(ph != 1));
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 58;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 58;
            end
            default: begin
               send_idle_pct = 11;
               rsp_stall_pct = 11;
            end
         endcase
         send_random(PHASE_PIXELS);
      end

      wait_drained();
      if (sb.mismatch_count == 0) begin
         $display("tb_pixel_to_ascii_text_encoder: PASS");
      end else begin
         $display("tb_pixel_to_ascii_text_encoder: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pta_pkg.sv
rtl/pta_front.sv
rtl/pta_queue.sv
rtl/pta_back.sv
rtl/pixel_to_ascii_text_encoder.sv
dv/tb_pixel_to_ascii_text_encoder.sv
